>>> design/wtt_pkg.sv
package wtt_pkg;

  // payload and configuration widths
  localparam int SAMPLE_W  = 24;
  localparam int T_W       = 32;
  localparam int SIZE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_GROUP_SIZE = 255;
  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int MIN_GROUP_SIZE     = 2;
  localparam int FEW_MARGIN         = 3;

  // accumulator widths
  localparam int POS_W = 9;
  localparam int SUM_W = 32;
  localparam int SQ_W  = 56;

  // finishing arithmetic widths
  localparam int PROD_W = 64;
  localparam int A_W    = 42;
  localparam int AMAG_W = 40;
  localparam int D_W    = 62;
  localparam int NN_W   = 16;
  localparam int F_W    = 24;
  localparam int MM_W   = 96;
  localparam int MN_W   = 40;
  localparam int DEN_W  = 87;
  localparam int Q_W    = 62;
  localparam int NUM_SH = 30;
  localparam int FRAC_W = 32;
  localparam int RES_W  = 31;

  localparam int DIV_STEPS  = 62;
  localparam int SQRT_STEPS = 31;
  localparam int ITER_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP1_SIZE = 1'b0,
    CFG_GROUP2_SIZE = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    RR_OK       = 3'd0,
    RR_FEW1     = 3'd1,
    RR_FEW2     = 3'd2,
    RR_ZERO_VAR = 3'd3,
    RR_SAT      = 3'd4
  } reason_t;

  typedef enum logic [1:0] {
    MO_AA  = 2'd0,
    MO_NUM = 2'd1,
    MO_D1  = 2'd2,
    MO_D2  = 2'd3
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IN,
    ST_ACC,
    ST_PROD,
    ST_DIFF,
    ST_CHECK,
    ST_MUL_LD,
    ST_MUL_RUN,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_SQRT_LD,
    ST_SQRT_RUN,
    ST_FIN,
    ST_OUT
  } wtt_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_bad;
  } in_item_t;

  typedef struct packed {
    logic signed [T_W-1:0] t_value;
    logic                  voxel_valid;
    logic [2:0]            reject_reason;
  } out_item_t;

  typedef struct packed {
    logic    take;
    logic    acc;
    logic    prod;
    logic    diff;
    logic    res_load;
    reason_t res_reason;
    logic    mul_load;
    logic    mul_run;
    logic    mul_store;
    mul_op_t mul_op;
    logic    div_load;
    logic    div_step;
    logic    sqrt_load;
    logic    sqrt_step;
    logic    clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic few1;
    logic few2;
    logic dzero;
    logic mul_done;
    logic sat;
    logic iter_last;
  } dp_status_t;

endpackage

>>> design/wtt_ctrl.sv
module wtt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  wtt_pkg::dp_status_t status,
  output wtt_pkg::ctrl_cmd_t  cmd,
  output logic                in_ready,
  output logic                out_valid
);
  import wtt_pkg::*;

  wtt_state_t state_r, state_nxt;
  mul_op_t    mul_op_r, mul_op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IN;
      mul_op_r <= MO_AA;
    end else begin
      state_r  <= state_nxt;
      mul_op_r <= mul_op_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    mul_op_nxt = mul_op_r;
    case (state_r)
      ST_IN:      if (in_valid) state_nxt = ST_ACC;
      ST_ACC:     state_nxt = status.last ? ST_PROD : ST_IN;
      ST_PROD:    state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.few1 || status.few2 || status.dzero) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt  = ST_MUL_LD;
          mul_op_nxt = MO_AA;
        end
      end
      ST_MUL_LD:  state_nxt = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (status.mul_done) begin
          case (mul_op_r)
            MO_AA:   begin state_nxt = ST_MUL_LD; mul_op_nxt = MO_NUM; end
            MO_NUM:  begin state_nxt = ST_MUL_LD; mul_op_nxt = MO_D1; end
            MO_D1:   begin state_nxt = ST_MUL_LD; mul_op_nxt = MO_D2; end
            default: state_nxt = ST_DIV_LD;
          endcase
        end
      end
      ST_DIV_LD:   state_nxt = status.sat ? ST_OUT : ST_DIV_RUN;
      ST_DIV_RUN:  if (status.iter_last) state_nxt = ST_SQRT_LD;
      ST_SQRT_LD:  state_nxt = ST_SQRT_RUN;
      ST_SQRT_RUN: if (status.iter_last) state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_OUT;
      ST_OUT:      if (out_ready) state_nxt = ST_IN;
      default:     state_nxt = ST_IN;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.mul_op = mul_op_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_IN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_ACC:  cmd.acc  = 1'b1;
      ST_PROD: cmd.prod = 1'b1;
      ST_DIFF: cmd.diff = 1'b1;
      ST_CHECK: begin
        if (status.few1) begin
          cmd.res_load   = 1'b1;
          cmd.res_reason = RR_FEW1;
        end else if (status.few2) begin
          cmd.res_load   = 1'b1;
          cmd.res_reason = RR_FEW2;
        end else if (status.dzero) begin
          cmd.res_load   = 1'b1;
          cmd.res_reason = RR_ZERO_VAR;
        end
      end
      ST_MUL_LD: cmd.mul_load = 1'b1;
      ST_MUL_RUN: begin
        cmd.mul_run   = 1'b1;
        cmd.mul_store = status.mul_done;
      end
      ST_DIV_LD: begin
        if (status.sat) begin
          cmd.res_load   = 1'b1;
          cmd.res_reason = RR_SAT;
        end else begin
          cmd.div_load = 1'b1;
        end
      end
      ST_DIV_RUN:  cmd.div_step  = 1'b1;
      ST_SQRT_LD:  cmd.sqrt_load = 1'b1;
      ST_SQRT_RUN: cmd.sqrt_step = 1'b1;
      ST_FIN: begin
        cmd.res_load   = 1'b1;
        cmd.res_reason = RR_OK;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/wtt_dp.sv
module wtt_dp #(
  parameter int MAX_GROUP_SIZE = wtt_pkg::DEF_MAX_GROUP_SIZE,
  parameter int SAMPLE_WIDTH   = wtt_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtt_pkg::in_item_t             in_data,
  input  logic                          cfg_we,
  input  logic [wtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtt_pkg::SIZE_W-1:0]    cfg_wdata,
  input  wtt_pkg::ctrl_cmd_t            cmd,
  output wtt_pkg::dp_status_t           status,
  output wtt_pkg::out_item_t            out_data
);
  import wtt_pkg::*;

  localparam logic [SIZE_W-1:0] MaxN = SIZE_W'(MAX_GROUP_SIZE);
  localparam logic [SIZE_W-1:0] MinN = SIZE_W'(MIN_GROUP_SIZE);

  // configuration
  logic [SIZE_W-1:0] size1_r, size2_r, n1, n2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size1_r <= MinN;
      size2_r <= MinN;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_GROUP1_SIZE: size1_r <= cfg_wdata;
        CFG_GROUP2_SIZE: size2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n1 = (size1_r < MinN) ? MinN : (size1_r > MaxN) ? MaxN : size1_r;
  assign n2 = (size2_r < MinN) ? MinN : (size2_r > MaxN) ? MaxN : size2_r;

  // sample capture, low bits sign extended, bad samples as zero
  logic signed [SAMPLE_WIDTH-1:0] xs;
  logic signed [SAMPLE_W-1:0]     x_in, x_r;

  assign xs   = in_data.sample[SAMPLE_WIDTH-1:0];
  assign x_in = in_data.sample_bad ? '0 : SAMPLE_W'(xs);

  always_ff @(posedge clk) begin
    if (cmd.take) x_r <= x_in;
  end

  // running sums
  logic [POS_W-1:0]        pos_r;
  logic signed [SUM_W-1:0] sum1_r, sum2_r;
  logic [SQ_W-1:0]         sq1_r, sq2_r;
  logic [SIZE_W-1:0]       cnt1_r, cnt2_r;
  logic signed [2*SAMPLE_W-1:0] x_sq;
  logic                    in_g1;

  assign x_sq  = x_r * x_r;
  assign in_g1 = pos_r < POS_W'(n1);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear || cfg_we) begin
      pos_r  <= '0;
      sum1_r <= '0;
      sum2_r <= '0;
      sq1_r  <= '0;
      sq2_r  <= '0;
      cnt1_r <= '0;
      cnt2_r <= '0;
    end else if (cmd.acc) begin
      pos_r <= pos_r + POS_W'(1);
      if (in_g1) begin
        sum1_r <= sum1_r + SUM_W'(x_r);
        sq1_r  <= sq1_r + SQ_W'($unsigned(x_sq));
        if (x_r != '0) cnt1_r <= cnt1_r + SIZE_W'(1);
      end else begin
        sum2_r <= sum2_r + SUM_W'(x_r);
        sq2_r  <= sq2_r + SQ_W'($unsigned(x_sq));
        if (x_r != '0) cnt2_r <= cnt2_r + SIZE_W'(1);
      end
    end
  end

  assign status.last = pos_r == POS_W'(n1) + POS_W'(n2) - POS_W'(1);
  assign status.few1 = (POS_W'(cnt1_r) + POS_W'(FEW_MARGIN)) < POS_W'(n1);
  assign status.few2 = (POS_W'(cnt2_r) + POS_W'(FEW_MARGIN)) < POS_W'(n2);

  // first products: squares of sums, scaled square sums, mean difference, group-size products
  logic signed [PROD_W-1:0] s1sq_c, s2sq_c;
  logic signed [A_W-1:0]    a_c;
  logic [PROD_W-1:0]        s1sq_r, s2sq_r, nsq1_r, nsq2_r;
  logic signed [A_W-1:0]    a_r;
  logic [NN_W-1:0]          nn1_r, nn2_r, f12_r;
  logic [SIZE_W-1:0]        n1m1, n2m1;

  assign s1sq_c = PROD_W'(sum1_r) * PROD_W'(sum1_r);
  assign s2sq_c = PROD_W'(sum2_r) * PROD_W'(sum2_r);
  assign a_c    = A_W'(sum1_r) * A_W'($signed({1'b0, n2}))
                - A_W'(sum2_r) * A_W'($signed({1'b0, n1}));
  assign n1m1   = n1 - SIZE_W'(1);
  assign n2m1   = n2 - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      s1sq_r <= $unsigned(s1sq_c);
      s2sq_r <= $unsigned(s2sq_c);
      nsq1_r <= PROD_W'(n1) * PROD_W'(sq1_r);
      nsq2_r <= PROD_W'(n2) * PROD_W'(sq2_r);
      a_r    <= a_c;
      nn1_r  <= NN_W'(n1) * NN_W'(n1);
      nn2_r  <= NN_W'(n2) * NN_W'(n2);
      f12_r  <= NN_W'(n1m1) * NN_W'(n2m1);
    end
  end

  // scaled variances and denominator factors
  logic [D_W-1:0]    d1_r, d2_r;
  logic [F_W-1:0]    f1_r, f2_r;
  logic              a_neg_r;
  logic [AMAG_W-1:0] amag_r;
  logic [PROD_W-1:0] d1_c, d2_c;

  assign d1_c = nsq1_r - s1sq_r;
  assign d2_c = nsq2_r - s2sq_r;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      d1_r    <= d1_c[D_W-1:0];
      d2_r    <= d2_c[D_W-1:0];
      f1_r    <= F_W'(nn1_r) * F_W'(n1m1);
      f2_r    <= F_W'(nn2_r) * F_W'(n2m1);
      a_neg_r <= a_r < 0;
      amag_r  <= (a_r < 0) ? AMAG_W'(-a_r) : AMAG_W'(a_r);
    end
  end

  assign status.dzero = (d1_r == '0) || (d2_r == '0);

  // shift-add multiplier, one multiplier bit per cycle
  logic [MM_W-1:0]  m_r, p_r;
  logic [MN_W-1:0]  mn_r;
  logic [MM_W-1:0]  num_r;
  logic [DEN_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      p_r <= '0;
      case (cmd.mul_op)
        MO_AA:  begin m_r <= MM_W'(amag_r); mn_r <= amag_r; end
        MO_NUM: begin m_r <= p_r;           mn_r <= MN_W'(f12_r); end
        MO_D1:  begin m_r <= MM_W'(d1_r);   mn_r <= MN_W'(f2_r); end
        default: begin m_r <= MM_W'(d2_r);  mn_r <= MN_W'(f1_r); end
      endcase
    end else if (cmd.mul_run) begin
      if (mn_r[0]) p_r <= p_r + m_r;
      m_r  <= m_r << 1;
      mn_r <= mn_r >> 1;
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        MO_NUM:  num_r <= p_r;
        MO_D1:   den_r <= p_r[DEN_W-1:0];
        MO_D2:   den_r <= den_r + p_r[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.mul_done = mn_r == '0;

  // restoring division of num * 2^32 by den, quotient below 2^62
  logic [DEN_W-1:0]  rem_r;
  logic [Q_W-1:0]    nlo_r, q_r;
  logic [ITER_W-1:0] iter_r;
  logic [DEN_W:0]    trial, trial_diff;
  logic              trial_ge;
  logic [Q_W-1:0]    res_r, one_r, rs_sum;
  logic              rs_ge;

  assign status.sat = DEN_W'(num_r[MM_W-1:NUM_SH]) >= den_r;
  assign trial      = {rem_r, nlo_r[Q_W-1]};
  assign trial_ge   = trial >= {1'b0, den_r};
  assign trial_diff = trial - {1'b0, den_r};
  assign rs_sum     = res_r + one_r;
  assign rs_ge      = q_r >= rs_sum;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= DEN_W'(num_r[MM_W-1:NUM_SH]);
      nlo_r  <= {num_r[NUM_SH-1:0], {FRAC_W{1'b0}}};
      q_r    <= '0;
      iter_r <= ITER_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r    <= {q_r[Q_W-2:0], trial_ge};
      nlo_r  <= nlo_r << 1;
      iter_r <= iter_r - ITER_W'(1);
    end else if (cmd.sqrt_load) begin
      res_r  <= '0;
      one_r  <= Q_W'(1) << (Q_W - 2);
      iter_r <= ITER_W'(SQRT_STEPS);
    end else if (cmd.sqrt_step) begin
      // digit-by-digit square root, q_r holds the remainder
      if (rs_ge) begin
        q_r   <= q_r - rs_sum;
        res_r <= (res_r >> 1) + one_r;
      end else begin
        res_r <= res_r >> 1;
      end
      one_r  <= one_r >> 2;
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  assign status.iter_last = iter_r == ITER_W'(1);

  // result register
  logic [T_W-1:0] mag;
  out_item_t      out_r;

  assign mag = T_W'(res_r[RES_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.reject_reason <= cmd.res_reason;
      case (cmd.res_reason)
        RR_OK: begin
          out_r.t_value     <= a_neg_r ? $signed(-mag) : $signed(mag);
          out_r.voxel_valid <= 1'b1;
        end
        RR_SAT: begin
          out_r.t_value     <= a_neg_r ? $signed({1'b1, {(T_W-1){1'b0}}})
                                       : $signed({1'b0, {(T_W-1){1'b1}}});
          out_r.voxel_valid <= 1'b1;
        end
        default: begin
          out_r.t_value     <= '0;
          out_r.voxel_valid <= 1'b0;
        end
      endcase
    end
  end

  assign out_data = out_r;

endmodule

>>> design/welch_two_sample_t_statistic.sv
// each sample transaction is captured, then accumulated; no new sample is taken in between
// after the last sample of a voxel the result is formed by the shift-add multiplier,
// then a 62-step divider and a 31-step square root (a saturated quotient skips both)
// rejected voxels (few nonzero, zero variance) skip the multiply, divide and square root
// rst_n is synchronous, active low: group sizes return to 2, sums and counts clear

module welch_two_sample_t_statistic #(
  parameter int MAX_GROUP_SIZE = wtt_pkg::DEF_MAX_GROUP_SIZE,
  parameter int SAMPLE_WIDTH   = wtt_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wtt_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output wtt_pkg::out_item_t            out_data,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [wtt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtt_pkg::SIZE_W-1:0]    cfg_wdata
);
  import wtt_pkg::*;

  // command and status between the sequencer and the arithmetic
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // the controller walks each voxel: sample intake, products, checks,
  // the multiply / divide / square root chain, then holds the result
  wtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // the datapath keeps the exact sums per group and forms
  // t^2 * 2^32 = A^2 (n1-1)(n2-1) 2^32 / (D1 n2^2 (n2-1) + D2 n1^2 (n1-1))
  // with the sign of t taken from A
  wtt_dp #(
    .MAX_GROUP_SIZE (MAX_GROUP_SIZE),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // sample intake and result hold never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("sample intake while a result is pending");

  // a rejected voxel always carries a zero t value
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.voxel_valid) |-> (out_data.t_value == '0))
    else $error("rejected voxel with nonzero t value");

  // computed and saturated results are flagged valid, rejects are not
  a_reason_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.voxel_valid ==
                   (out_data.reject_reason == RR_OK ||
                    out_data.reject_reason == RR_SAT)))
    else $error("voxel_valid disagrees with reject_reason");

endmodule
